// ===== src/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants of the streaming substring matcher.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // Pattern storage: four 64-bit words, eight bytes each
  localparam int PAT_WORDS  = 4;
  localparam int WORD_BITS  = 64;
  localparam int PAT_BYTES  = PAT_WORDS * WORD_BITS / 8;
  localparam int LEN_BITS   = 6;

  // Result field widths
  localparam int START_BITS = 32;
  localparam int COUNT_BITS = 32;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD_0 = 3'd1,
    REG_PATTERN_WORD_1 = 3'd2,
    REG_PATTERN_WORD_2 = 3'd3,
    REG_PATTERN_WORD_3 = 3'd4
  } ssm_reg_t;

  // Result kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  // Pattern configuration as seen by the front
  typedef struct packed {
    logic [LEN_BITS-1:0]                len;
    logic [PAT_WORDS-1:0][WORD_BITS-1:0] words;
  } ssm_cfg_t;

  // One classified request handed from front to back
  typedef struct packed {
    logic                  hit;
    logic                  last;
    logic [START_BITS-1:0] start;
  } ssm_entry_t;

endpackage

// ===== src/streaming_substring_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// streaming_substring_matcher_unit
// Exact substring search over a byte stream with overlapping match reports
// and a saturating match total at the end of each sequence.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                    Contents
//  s_axis    in         tvalid tready tdata tlast  seq_byte, end_of_sequence
//  m_axis    out        tvalid tready tdata tuser  match_start, match_total,
//                       tlast                      result_kind, last_result
//  cfg       in         we index data              pattern_length, words 0..3
//
//  One byte per cycle while the queue has room: the front compares the whole
//  window at once and the back issues one result per cycle from its output
//  register while m_axis is ready. A match on the final byte adds a second
//  result; the four-entry queue absorbs it. Reset is synchronous and clears
//  counters, queue and configuration (length 1, pattern zero); there is no
//  clearing pass. m_axis stalls back up through the queue to s_axis tready.
// ----------------------------------------------------------------------------
module streaming_substring_matcher_unit import ssm_pkg::*; #(
  parameter int PATTERN_MAX = 32,
  parameter int INDEX_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // seq_byte
  input  logic                              s_axis_tlast,   // end_of_sequence
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [START_BITS+COUNT_BITS-1:0]  m_axis_tdata,   // match_start, match_total
  output logic                              m_axis_tuser,   // result_kind
  output logic                              m_axis_tlast,   // last_result
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [WORD_BITS-1:0]              cfg_data
);

  ssm_cfg_t   cfg;
  logic       push;
  ssm_entry_t push_entry;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  ssm_entry_t q_entry;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.len   <= LEN_BITS'(1);
      cfg.words <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: cfg.len      <= cfg_data[LEN_BITS-1:0];
        REG_PATTERN_WORD_0: cfg.words[0] <= cfg_data;
        REG_PATTERN_WORD_1: cfg.words[1] <= cfg_data;
        REG_PATTERN_WORD_2: cfg.words[2] <= cfg_data;
        REG_PATTERN_WORD_3: cfg.words[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  ssm_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .INDEX_BITS  (INDEX_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ssm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .nonempty   (q_valid),
    .pop_entry  (q_entry)
  );

  ssm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== src/ssm_front.sv =====
// ----------------------------------------------------------------------------
// ssm_front
// Accepts sequence bytes, shifts the byte window, compares the pattern in
// parallel and classifies each request as match, end of sequence or both.
// ----------------------------------------------------------------------------
module ssm_front import ssm_pkg::*; #(
  parameter int PATTERN_MAX = 32,
  parameter int INDEX_BITS  = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  ssm_cfg_t         cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic             q_full,
  output logic             push,
  output ssm_entry_t       push_entry
);

  localparam int WIN_BITS  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int EXT_BYTES = (PATTERN_MAX > PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
  localparam int START_EXT = (INDEX_BITS > START_BITS) ? INDEX_BITS : START_BITS;
  localparam logic [INDEX_BITS-1:0] SEEN_MAX = '1;

  logic [7:0]            win [PATTERN_MAX];
  logic [7:0]            win_next [PATTERN_MAX];
  logic [INDEX_BITS-1:0] seen;
  logic [INDEX_BITS-1:0] seen_inc;
  logic [INDEX_BITS-1:0] start_full;
  logic [START_EXT-1:0]  start_ext;
  logic [8*EXT_BYTES-1:0] pat_wide;
  logic                  len_ok;
  logic                  enough;
  logic                  all_eq;
  logic                  hit;
  logic                  accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pat_wide = (8*EXT_BYTES)'(cfg.words);

  // Shift the new byte into the window, newest at entry 0
  always_comb begin
    win_next[0] = in_byte;
    for (int i = 1; i < PATTERN_MAX; i++) begin
      win_next[i] = win[i-1];
    end
  end

  // Compare pattern byte k against window entry len-1-k
  always_comb begin
    logic [6:0] sel;
    all_eq = 1'b1;
    sel    = '0;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (7'(k) < {1'b0, cfg.len}) begin
        sel = {1'b0, cfg.len} - 7'd1 - 7'(k);
        if (win_next[sel[WIN_BITS-1:0]] != pat_wide[k*8 +: 8]) begin
          all_eq = 1'b0;
        end
      end
    end
  end

  // Classify: length in range, enough bytes, all bytes equal
  assign seen_inc   = (seen != SEEN_MAX) ? seen + INDEX_BITS'(1) : seen;
  assign len_ok     = (cfg.len != '0) && ({1'b0, cfg.len} <= 7'(PATTERN_MAX));
  assign enough     = seen_inc >= INDEX_BITS'(cfg.len);
  assign hit        = len_ok && enough && all_eq;
  assign start_full = seen + INDEX_BITS'(1) - INDEX_BITS'(cfg.len);
  assign start_ext  = START_EXT'(start_full);

  assign push             = accept && (hit || in_last);
  assign push_entry.hit   = hit;
  assign push_entry.last  = in_last;
  assign push_entry.start = start_ext[START_BITS-1:0];

  // Advance the byte counter, clear it after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (accept) begin
      seen <= in_last ? '0 : seen_inc;
    end
  end

  // Hold the window
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

endmodule

// ===== src/ssm_queue.sv =====
// ----------------------------------------------------------------------------
// ssm_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module ssm_queue import ssm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ssm_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       nonempty,
  output ssm_entry_t pop_entry
);

  ssm_entry_t           mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_pop;

  assign full      = count == (QPTR_BITS+1)'(QUEUE_DEPTH);
  assign nonempty  = count != '0;
  assign do_pop    = pop && nonempty;
  assign pop_entry = mem[rd_ptr];

  // Store pushed request
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !do_pop) begin
        count <= count + (QPTR_BITS+1)'(1);
      end else if (!push && do_pop) begin
        count <= count - (QPTR_BITS+1)'(1);
      end
    end
  end

endmodule

// ===== src/ssm_back.sv =====
// ----------------------------------------------------------------------------
// ssm_back
// Counts matches and emits start positions and the final total through an
// output register.
// ----------------------------------------------------------------------------
module ssm_back import ssm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  ssm_entry_t                   q_entry,
  output logic                         q_pop,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [START_BITS+COUNT_BITS-1:0] m_axis_tdata,  // match_start, match_total
  output logic                         m_axis_tuser,  // result_kind
  output logic                         m_axis_tlast   // last_result
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic                  load;
  logic                  emit_start;
  logic                  total_pending;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_inc;
  logic [START_BITS-1:0] out_start;
  logic [COUNT_BITS-1:0] out_total;

  assign load       = q_valid && (!m_axis_tvalid || m_axis_tready);
  assign emit_start = q_entry.hit && !total_pending;
  assign q_pop      = load && !(emit_start && q_entry.last);
  assign count_inc  = (count != COUNT_MAX) ? count + COUNT_BITS'(1) : count;
  assign m_axis_tdata = {out_total, out_start};

  // Control: output valid, pending total, match counter
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      total_pending <= 1'b0;
      count         <= '0;
    end else begin
      if (!m_axis_tvalid || m_axis_tready) begin
        m_axis_tvalid <= q_valid;
      end
      if (load) begin
        if (emit_start) begin
          count         <= count_inc;
          total_pending <= q_entry.last;
        end else begin
          count         <= '0;
          total_pending <= 1'b0;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_start) begin
        m_axis_tuser <= KIND_START;
        out_start    <= q_entry.start;
        out_total    <= '0;
        m_axis_tlast <= !q_entry.last;
      end else begin
        m_axis_tuser <= KIND_TOTAL;
        out_start    <= '0;
        out_total    <= count;
        m_axis_tlast <= 1'b1;
      end
    end
  end

endmodule
